[src/fixed_block_free_list_allocator_macros.svh]
// Assertion macros for the fixed block free list allocator.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FBFLA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FBFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/fbfla_pkg.sv]
// Shared types for the fixed block free list allocator.
// No dependencies; imported by the controller, datapath and top level.
package fbfla_pkg;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic load;
		logic commit;
	} cmd_t;

endpackage

[src/fbfla_ctrl.sv]
// Controller for the fixed block free list allocator: request sequencing and output beat valid.
// Depends on fbfla_pkg and fixed_block_free_list_allocator_macros.svh.
`include "fixed_block_free_list_allocator_macros.svh"

module fbfla_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output fbfla_pkg::cmd_t cmd
);
	import fbfla_pkg::*;

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n    = state_q;
		in_stall   = 1'b1;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// link read lands this cycle; commit once the output slot frees
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`FBFLA_ASSERT_NOW(a_no_overwrite, clk, arst_n, out_valid_q && out_stall, !cmd.commit, "result overwritten while stalled")
	`FBFLA_ASSERT_NEXT(a_load_exec, clk, arst_n, cmd.load, state_q == ST_EXEC, "load did not enter exec")
	`FBFLA_ASSERT_NEXT(a_commit_valid, clk, arst_n, cmd.commit, out_valid_q, "commit gave no output beat")
	`FBFLA_ASSERT_NOW(a_one_cmd, clk, arst_n, 1'b1, !(cmd.load && cmd.commit), "load and commit together")

endmodule

[src/fbfla_dp.sv]
// Datapath for the fixed block free list allocator: link memory, head, counters, result register.
// Depends on fbfla_pkg; driven by fbfla_ctrl commands.
module fbfla_dp #(
	parameter int BLOCKS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  fbfla_pkg::cmd_t cmd,
	input  logic            func,
	input  logic [3:0]      block_index,
	output logic            granted,
	output logic [3:0]      given_index,
	output logic [4:0]      blocks_free,
	output logic [4:0]      blocks_used,
	output logic [4:0]      peak_used,
	output logic [31:0]     failed_requests
);
	import fbfla_pkg::*;

	localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
	localparam int LW = $clog2(BLOCKS + 1);
	localparam int XW = (LW > 4) ? LW : 4;
	localparam int OW = (LW > 5) ? LW : 5;

	logic              func_q;
	logic [3:0]        idx_q;
	logic [LW-1:0]     head_q;
	logic [LW-1:0]     free_q;
	logic [LW-1:0]     peak_q;
	logic [31:0]       refusals_q;
	logic [LW-1:0]     link_mem [BLOCKS];
	logic [BLOCKS-1:0] link_valid_q;
	logic [LW-1:0]     rd_q;

	logic              granted_q;
	logic [3:0]        given_q;
	logic [4:0]        free_out_q;
	logic [4:0]        used_out_q;
	logic [4:0]        peak_out_q;

	logic [IW-1:0]     head_addr;
	logic [XW-1:0]     idx_x;
	logic [XW-1:0]     head_x;
	logic [IW-1:0]     wr_addr;
	logic              wr_en;
	logic              alloc_ok;
	logic              rel_ok;
	logic [LW-1:0]     free_n;
	logic [LW-1:0]     used_n;
	logic [LW-1:0]     peak_n;
	logic [LW-1:0]     head_n;
	logic [31:0]       refusals_n;
	logic [OW-1:0]     free_o;
	logic [OW-1:0]     used_o;
	logic [OW-1:0]     peak_o;

	assign head_addr = head_q[IW-1:0];
	assign idx_x     = XW'(idx_q);
	assign head_x    = XW'(head_q);
	assign wr_addr   = idx_x[IW-1:0];

	always_comb begin
		alloc_ok = !func_q && (free_q != '0) && (head_q < LW'(BLOCKS));
		rel_ok   = func_q && (idx_x < XW'(BLOCKS)) && (free_q != LW'(BLOCKS));
		wr_en    = cmd.commit && rel_ok;
		if (alloc_ok) begin
			free_n = free_q - LW'(1);
			head_n = rd_q;
		end else if (rel_ok) begin
			free_n = free_q + LW'(1);
			head_n = idx_x[LW-1:0];
		end else begin
			free_n = free_q;
			head_n = head_q;
		end
		used_n = LW'(BLOCKS) - free_n;
		peak_n = (alloc_ok && (used_n > peak_q)) ? used_n : peak_q;
		refusals_n = refusals_q;
		if (!func_q && !alloc_ok && (refusals_q != '1)) begin
			refusals_n = refusals_q + 32'd1;
		end
	end

	assign free_o = OW'(free_n);
	assign used_o = OW'(used_n);
	assign peak_o = OW'(peak_n);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			idx_q  <= block_index;
		end
	end

	// link memory; an entry never written reads as its successor index
	always_ff @(posedge clk) begin
		if (wr_en) begin
			link_mem[wr_addr] <= head_q;
		end
		rd_q <= link_valid_q[head_addr] ? link_mem[head_addr] : (LW'(head_addr) + LW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_valid_q <= '0;
			head_q       <= '0;
			free_q       <= LW'(BLOCKS);
			peak_q       <= '0;
			refusals_q   <= '0;
		end else begin
			if (wr_en) begin
				link_valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.commit) begin
				head_q     <= head_n;
				free_q     <= free_n;
				peak_q     <= peak_n;
				refusals_q <= refusals_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			granted_q  <= alloc_ok;
			given_q    <= alloc_ok ? head_x[3:0] : 4'd0;
			free_out_q <= free_o[4:0];
			used_out_q <= used_o[4:0];
			peak_out_q <= peak_o[4:0];
		end
	end

	assign granted         = granted_q;
	assign given_index     = given_q;
	assign blocks_free     = free_out_q;
	assign blocks_used     = used_out_q;
	assign peak_used       = peak_out_q;
	assign failed_requests = refusals_q;

endmodule

[src/fixed_block_free_list_allocator.sv]
// Fixed block free list allocator: a pool of BLOCKS equal blocks kept as a LIFO free list.
// Takes one request beat (func 0 allocates the head block, func 1 releases block_index)
// and returns one result beat with the grant, the block given and the pool counters.
// Channels: in_valid/in_stall carry requests, out_valid/out_stall carry results;
// a beat moves on a clock edge with valid high and stall low.
// A result is registered once the request is taken, the link memory read at the head has landed
// and the output slot is free. A new request is taken only once the last one has committed.
// The next request is taken while a result waits; it completes once that result is gone.
// When the receiver stalls, the result and its fields hold; no result is lost.
// Refused allocates bump a saturating 32-bit counter. Counts are given modulo 32.
// Reset (arst_n low, asynchronous) empties the channels, frees every block, clears
// the peak and refusal counts and marks every link as pointing to its successor at once.
// Depends on fbfla_pkg, fbfla_ctrl and fbfla_dp.
module fixed_block_free_list_allocator #(
	parameter int BLOCKS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [3:0]  block_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        granted,
	output logic [3:0]  given_index,
	output logic [4:0]  blocks_free,
	output logic [4:0]  blocks_used,
	output logic [4:0]  peak_used,
	output logic [31:0] failed_requests
);
	import fbfla_pkg::*;

	cmd_t cmd;

	fbfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	fbfla_dp #(
		.BLOCKS (BLOCKS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.func            (func),
		.block_index     (block_index),
		.granted         (granted),
		.given_index     (given_index),
		.blocks_free     (blocks_free),
		.blocks_used     (blocks_used),
		.peak_used       (peak_used),
		.failed_requests (failed_requests)
	);

endmodule

[verif/tb_fixed_block_free_list_allocator.sv]
`timescale 1ns / 100ps
// Testbench for fixed_block_free_list_allocator: allocate/release requests checked beat by beat
// against an in-bench model of the LIFO free list and its counters. Needs only the RTL.
module tb_fixed_block_free_list_allocator;

	localparam int POOL = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_CAP = 30;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef struct packed {
		logic [POOL-1:0][4:0] link;
		logic [4:0]           head;
		logic [4:0]           free_cnt;
		logic [4:0]           peak;
		logic [31:0]          refused;
	} pool_t;

	typedef struct packed {
		logic        granted;
		logic [3:0]  given;
		logic [4:0]  nfree;
		logic [4:0]  nused;
		logic [4:0]  peak;
		logic [31:0] fails;
	} grant_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] idx;
		logic       hold;
		logic       calm;
	} req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        func = 1'b0;
	logic [3:0]  block_index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        granted;
	logic [3:0]  given_index;
	logic [4:0]  blocks_free;
	logic [4:0]  blocks_used;
	logic [4:0]  peak_used;
	logic [31:0] failed_requests;

	req_t        pending[$];
	grant_t      expected_grants[$];
	pool_t       pool;
	pool_t       plan_pool;
	logic [15:0] held;
	logic        drained = 1'b1;
	logic        calm = 1'b0;
	logic [2:0]  gap = '0;
	logic [2:0]  stall_left = '0;
	int          mismatches = 0;

	fixed_block_free_list_allocator #(
		.BLOCKS(POOL)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.block_index(block_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.granted(granted),
		.given_index(given_index),
		.blocks_free(blocks_free),
		.blocks_used(blocks_used),
		.peak_used(peak_used),
		.failed_requests(failed_requests)
	);

	function automatic pool_t fresh_pool();
		pool_t p;
		p = '0;
		for (int i = 0; i < POOL; i++)
			p.link[i] = 5'(i + 1);
		p.free_cnt = 5'(POOL);
		return p;
	endfunction

	// pop the head on allocate, push onto the head on release
	function automatic grant_t serve_request(inout pool_t p, input op_t op, input logic [3:0] idx);
		grant_t r;
		logic [4:0] used;
		r = '0;
		if (op == OP_ALLOC) begin
			if (p.free_cnt == 0 || p.head >= POOL) begin
				if (p.refused != '1)
					p.refused = p.refused + 32'd1;
			end else begin
				r.granted = 1'b1;
				r.given = p.head[3:0];
				p.head = p.link[p.head[3:0]];
				p.free_cnt = p.free_cnt - 5'd1;
				used = 5'(POOL - p.free_cnt);
				if (used > p.peak)
					p.peak = used;
			end
		end else if (idx < POOL && p.free_cnt < POOL) begin
			p.link[idx] = p.head;
			p.head = {1'b0, idx};
			p.free_cnt = p.free_cnt + 5'd1;
		end
		r.nfree = p.free_cnt;
		r.nused = 5'(POOL - p.free_cnt);
		r.peak = p.peak;
		r.fails = p.refused;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		if (mismatches < PRINT_CAP)
			$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic plan(input op_t op, input logic [3:0] idx, input logic hold_it, input logic calm_it);
		grant_t r;
		req_t q;
		r = serve_request(plan_pool, op, idx);
		if (r.granted)
			held[r.given] = 1'b1;
		if (op == OP_RELEASE)
			held[idx] = 1'b0;
		q.op = op;
		q.idx = idx;
		q.hold = hold_it;
		q.calm = calm_it;
		pending.push_back(q);
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	// request side
	always @(posedge clk) begin : drive
		logic took;
		req_t nxt;
		took = in_valid && !in_stall;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !took) begin
			in_valid <= 1'b1;
		end else if (gap != 0) begin
			gap <= gap - 3'd1;
			in_valid <= 1'b0;
		end else if (pending.size() == 0 || (pending[0].hold && !(drained && !took))) begin
			in_valid <= 1'b0;
		end else begin
			nxt = pending.pop_front();
			calm <= nxt.calm;
			func <= nxt.op;
			block_index <= nxt.idx;
			in_valid <= 1'b1;
			if (!nxt.calm && $urandom_range(7) == 0)
				gap <= 3'($urandom_range(1, 5));
		end
	end

	// both channels watched here so the expectation queue has one writer
	always @(posedge clk) begin : watch
		grant_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_grants.push_back(serve_request(pool, op_t'(func), block_index));
			if (out_valid && !out_stall) begin
				if (expected_grants.size() == 0) begin
					report_mismatch("unexpected beat", 32'(given_index), '0);
				end else begin
					want = expected_grants.pop_front();
					if (granted !== want.granted)
						report_mismatch("granted", 32'(granted), 32'(want.granted));
					if (given_index !== want.given)
						report_mismatch("given_index", 32'(given_index), 32'(want.given));
					if (blocks_free !== want.nfree)
						report_mismatch("blocks_free", 32'(blocks_free), 32'(want.nfree));
					if (blocks_used !== want.nused)
						report_mismatch("blocks_used", 32'(blocks_used), 32'(want.nused));
					if (peak_used !== want.peak)
						report_mismatch("peak_used", 32'(peak_used), 32'(want.peak));
					if (failed_requests !== want.fails)
						report_mismatch("failed_requests", failed_requests, want.fails);
				end
			end
			drained <= (expected_grants.size() == 0);
			if (stall_left != 0) begin
				stall_left <= stall_left - 3'd1;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(9) == 0) begin
				stall_left <= 3'($urandom_range(0, 4));
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : main
		int bias;
		int roll;
		logic [3:0] pick;
		logic calm_it;
		pool = fresh_pool();
		plan_pool = fresh_pool();
		held = '0;

		// release with every block already free is dropped
		plan(OP_RELEASE, 4'hF, 1'b0, 1'b0);
		plan(OP_RELEASE, 4'h0, 1'b0, 1'b0);
		// drain the pool; block_index is don't-care on allocate
		for (int k = 0; k < POOL; k++)
			plan(OP_ALLOC, 4'(k) ^ 4'hF, 1'b0, 1'b0);
		// empty pool: refused, after a full drain of the result side
		plan(OP_ALLOC, 4'h5, 1'b1, 1'b0);
		plan(OP_ALLOC, 4'hA, 1'b0, 1'b0);
		plan(OP_RELEASE, 4'h9, 1'b0, 1'b0);
		plan(OP_RELEASE, 4'h3, 1'b0, 1'b0);
		plan(OP_ALLOC, 4'h0, 1'b0, 1'b0);
		plan(OP_ALLOC, 4'hF, 1'b0, 1'b0);

		// alternating fill-heavy and drain-heavy stretches; double releases only late
		for (int ph = 0; ph < 10; ph++) begin
			bias = (ph % 2 == 0) ? $urandom_range(60, 90) : $urandom_range(15, 40);
			calm_it = (ph == 9);
			for (int k = 0; k < 100; k++) begin
				roll = $urandom_range(99);
				if (ph >= 7 && roll < 6) begin
					plan(OP_RELEASE, 4'($urandom_range(15)), 1'b0, calm_it);
				end else if (roll < bias || held == '0) begin
					plan(OP_ALLOC, 4'($urandom_range(15)), (ph == 5 && k == 0), calm_it);
				end else begin
					do pick = 4'($urandom_range(15)); while (!held[pick]);
					plan(OP_RELEASE, pick, 1'b0, calm_it);
				end
			end
		end

		do @(negedge clk); while (pending.size() != 0 || in_valid || !drained);
		repeat (16) @(negedge clk);
		if (expected_grants.size() != 0)
			report_mismatch("results missing", '0, 32'(expected_grants.size()));
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
